### design/ruol_pkg.sv
// shared types and constants for the recent-use order list unit
// no dependencies
`timescale 1ns / 1ps

package ruol_pkg;

  // width of every entry, length and opcode-independent payload field
  localparam int unsigned FIELD_W = 5;

  // default list capacity
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // answer to a query on an empty list
  localparam logic [FIELD_W-1:0] EMPTY_SUCCESSOR = FIELD_W'(1);

  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_RESIZE = 2'd2
  } opcode_e;

endpackage

### design/recent_use_order_list_unit.sv
// recent-use order list unit: move-to-front list of entry numbers with a length
// uses ruol_pkg for field widths, opcodes and constants
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy then stays high
// until the request is finished. The list lives in a single-port-write,
// registered-read memory, and one small sequencer walks it one slot at a time,
// so each touched slot takes a read state and then a use state. A query scans
// to the position found and then reads the successor; a touch scans, shifts
// the slots before it down one place and writes the front; a grow writes each
// new slot, and a shrink reads each kept slot and clamps it. A touch that the
// list ignores, an empty query, a shrink to zero and opcode three finish in
// the accept cycle. A query answer shows on successor_entry_o for exactly one
// cycle with result_valid_o high; the receiver cannot stall it, so it must be
// taken then.
module recent_use_order_list_unit
  import ruol_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [FIELD_W-1:0] entry_number_i,
  input  logic [FIELD_W-1:0] new_length_i,
  output logic               result_valid_o,
  output logic [FIELD_W-1:0] successor_entry_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam logic [CMP_W-1:0] MaxLen = CMP_W'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FRONT_WR,
    ST_QRY_RD,
    ST_QRY_EV,
    ST_GROW,
    ST_SHRINK_RD,
    ST_SHRINK_WR
  } state_e;

  state_e               state_q;
  opcode_e              op_q;
  logic [FIELD_W-1:0]   entry_q;
  logic [CMP_W-1:0]     n_q;
  logic [FIELD_W-1:0]   len_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 result_valid_q;
  logic [FIELD_W-1:0]   successor_q;

  logic [FIELD_W-1:0]   mem_q [MAX_ENTRIES];
  logic [FIELD_W-1:0]   rd_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [FIELD_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  logic [CMP_W-1:0]     cnt_x;
  logic [CMP_W-1:0]     cnt_inc_x;
  logic [CMP_W-1:0]     len_x;
  logic [CMP_W-1:0]     new_len_x;
  logic [CMP_W-1:0]     n_sat;
  logic [CMP_W-1:0]     rd_x;
  logic                 hit;
  logic                 last;

  assign cnt_x     = CMP_W'(cnt_q);
  assign cnt_inc_x = cnt_x + CMP_W'(1);
  assign len_x     = CMP_W'(len_q);
  assign new_len_x = CMP_W'(new_length_i);
  assign n_sat     = (new_len_x > MaxLen) ? MaxLen : new_len_x;
  assign rd_x      = CMP_W'(rd_q);
  assign hit       = (rd_q == entry_q);
  assign last      = (cnt_inc_x >= len_x);

  assign busy              = (state_q != ST_IDLE);
  assign result_valid_o    = result_valid_q;
  assign successor_entry_o = successor_q;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[IDX_W-1:0];
    mem_wdata = rd_q;
    mem_raddr = cnt_q[IDX_W-1:0];
    case (state_q)
      ST_SHIFT_RD: begin
        mem_raddr = IDX_W'(cnt_q - CNT_W'(1));
      end
      ST_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      ST_FRONT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = entry_q;
      end
      ST_GROW: begin
        mem_we    = (cnt_x < n_q);
        mem_wdata = FIELD_W'(cnt_inc_x);
      end
      ST_SHRINK_WR: begin
        mem_we    = (rd_x > n_q);
        mem_wdata = FIELD_W'(n_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      len_q          <= '0;
      result_valid_q <= 1'b0;
      op_q           <= OP_TOUCH;
      entry_q        <= '0;
      n_q            <= '0;
      cnt_q          <= '0;
      successor_q    <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            op_q    <= opcode_e'(opcode_i);
            entry_q <= entry_number_i;
            n_q     <= n_sat;
            cnt_q   <= '0;
            case (opcode_e'(opcode_i))
              OP_TOUCH: begin
                if (len_q != '0 && entry_number_i <= len_q) begin
                  state_q <= ST_SCAN_RD;
                end
              end
              OP_QUERY: begin
                if (len_q == '0) begin
                  result_valid_q <= 1'b1;
                  successor_q    <= EMPTY_SUCCESSOR;
                end else begin
                  state_q <= ST_SCAN_RD;
                end
              end
              OP_RESIZE: begin
                if (n_sat >= len_x) begin
                  cnt_q   <= CNT_W'(len_q);
                  state_q <= ST_GROW;
                end else if (n_sat == '0) begin
                  len_q <= '0;
                end else begin
                  state_q <= ST_SHRINK_RD;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_EV;
        end
        ST_SCAN_EV: begin
          if (hit || last) begin
            if (op_q == OP_TOUCH) begin
              // a miss replaces the last slot
              if (hit) begin
                cnt_q   <= cnt_q;
                state_q <= (cnt_q == '0) ? ST_FRONT_WR : ST_SHIFT_RD;
              end else begin
                cnt_q   <= CNT_W'(len_q - FIELD_W'(1));
                state_q <= (len_q == FIELD_W'(1)) ? ST_FRONT_WR : ST_SHIFT_RD;
              end
            end else begin
              // successor exists only for a hit that is not last
              cnt_q   <= (hit && !last) ? CNT_W'(cnt_inc_x) : '0;
              state_q <= ST_QRY_RD;
            end
          end else begin
            cnt_q   <= CNT_W'(cnt_inc_x);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_SHIFT_RD: begin
          state_q <= ST_SHIFT_WR;
        end
        ST_SHIFT_WR: begin
          cnt_q   <= cnt_q - CNT_W'(1);
          state_q <= (cnt_q == CNT_W'(1)) ? ST_FRONT_WR : ST_SHIFT_RD;
        end
        ST_FRONT_WR: begin
          state_q <= ST_IDLE;
        end
        ST_QRY_RD: begin
          state_q <= ST_QRY_EV;
        end
        ST_QRY_EV: begin
          result_valid_q <= 1'b1;
          successor_q    <= rd_q;
          state_q        <= ST_IDLE;
        end
        ST_GROW: begin
          if (cnt_x < n_q) begin
            cnt_q <= CNT_W'(cnt_inc_x);
          end else begin
            len_q   <= FIELD_W'(n_q);
            state_q <= ST_IDLE;
          end
        end
        ST_SHRINK_RD: begin
          state_q <= ST_SHRINK_WR;
        end
        ST_SHRINK_WR: begin
          cnt_q <= CNT_W'(cnt_inc_x);
          if (cnt_inc_x >= n_q) begin
            len_q   <= FIELD_W'(n_q);
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_SHRINK_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/recent_use_order_list_unit_tb.sv
// self-checking testbench for the recent-use order list unit
// depends on ruol_pkg and recent_use_order_list_unit; directed then random requests
`timescale 1ns / 1ps

module recent_use_order_list_unit_tb;
  import ruol_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 50;

  // tracks the list contents and the answers that queries must give
  class successor_scoreboard;
    logic [FIELD_W-1:0] order_q [MAX_ENTRIES_DEF];
    logic [FIELD_W-1:0] length_q;
    logic [FIELD_W-1:0] successor_q [$];
    int unsigned errors;

    function new();
      foreach (order_q[i]) order_q[i] = '0;
      length_q = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return successor_q.size();
    endfunction

    function int unsigned length_now();
      return length_q;
    endfunction

    function int unsigned find_first(logic [FIELD_W-1:0] value);
      for (int unsigned i = 0; i < length_q; i++) begin
        if (order_q[i] == value) return i;
      end
      return length_q;
    endfunction

    // apply one accepted request to the list copy
    function void note_request(logic [1:0] op, logic [FIELD_W-1:0] ent,
                               logic [FIELD_W-1:0] nlen);
      int unsigned pos;
      int unsigned n;
      case (op)
        OP_TOUCH: begin
          if (length_q != 0 && ent <= length_q) begin
            pos = find_first(ent);
            // no match: the last element drops out
            if (pos >= length_q) pos = length_q - 1;
            for (int unsigned i = pos; i > 0; i--) order_q[i] = order_q[i-1];
            order_q[0] = ent;
          end
        end
        OP_QUERY: begin
          if (length_q == 0) begin
            successor_q.push_back(EMPTY_SUCCESSOR);
          end else begin
            pos = find_first(ent);
            if (pos + 1 < length_q) successor_q.push_back(order_q[pos+1]);
            else successor_q.push_back(order_q[0]);
          end
        end
        OP_RESIZE: begin
          n = (nlen > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : nlen;
          if (n >= length_q) begin
            for (int unsigned i = length_q; i < n; i++) order_q[i] = FIELD_W'(i + 1);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              if (order_q[i] > n) order_q[i] = FIELD_W'(n);
            end
          end
          length_q = FIELD_W'(n);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [FIELD_W-1:0] actual);
      logic [FIELD_W-1:0] expected;
      if (successor_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
      end else begin
        expected = successor_q.pop_front();
        if (actual !== expected) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: successor_entry mismatch, expected %0d, actual %0d",
                     $time, expected, actual);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode_i = OP_TOUCH;
  logic [FIELD_W-1:0] entry_number_i = '0;
  logic [FIELD_W-1:0] new_length_i = '0;
  logic               result_valid_o;
  logic [FIELD_W-1:0] successor_entry_o;

  successor_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  recent_use_order_list_unit #(
    .MAX_ENTRIES(MAX_ENTRIES_DEF)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .entry_number_i   (entry_number_i),
    .new_length_i     (new_length_i),
    .result_valid_o   (result_valid_o),
    .successor_entry_o(successor_entry_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_request(opcode_i, entry_number_i, new_length_i);
    if (rst_ni && result_valid_o) sb.check_result(successor_entry_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one request and return at the edge that accepts it
  task automatic send_request(input logic [1:0] op, input logic [FIELD_W-1:0] ent,
                              input logic [FIELD_W-1:0] nlen);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    opcode_i <= op;
    entry_number_i <= ent;
    new_length_i <= nlen;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned sel;
    logic [1:0] op;
    logic [FIELD_W-1:0] ent;
    logic [FIELD_W-1:0] nlen;
    pick = $urandom_range(99);
    if (pick < 42) op = OP_TOUCH;
    else if (pick < 84) op = OP_QUERY;
    else if (pick < 97) op = OP_RESIZE;
    else op = OP_UNUSED;
    // mostly entries that can be in the list, sometimes out of range
    sel = $urandom_range(99);
    if (sel < 70) ent = FIELD_W'($urandom_range(sb.length_now(), 0));
    else if (sel < 90) ent = FIELD_W'($urandom_range(16, 0));
    else ent = FIELD_W'($urandom_range(31, 0));
    if ($urandom_range(99) < 85) nlen = FIELD_W'($urandom_range(16, 0));
    else nlen = FIELD_W'($urandom_range(31, 17));
    send_request(op, ent, nlen);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list cases
    send_request(OP_QUERY, 5'd0, 5'd31);
    send_request(OP_TOUCH, 5'd0, 5'd0);
    send_request(OP_RESIZE, 5'd31, 5'd0);
    send_request(OP_QUERY, 5'd16, 5'd0);
    // grow beyond capacity saturates
    send_request(OP_RESIZE, 5'd0, 5'd31);
    send_request(OP_QUERY, 5'd16, 5'd0);
    send_request(OP_QUERY, 5'd1, 5'd0);
    send_request(OP_QUERY, 5'd0, 5'd0);
    send_request(OP_QUERY, 5'd31, 5'd31);
    send_request(OP_TOUCH, 5'd16, 5'd0);
    // zero is not in the list, so everything shifts down
    send_request(OP_TOUCH, 5'd0, 5'd0);
    send_request(OP_QUERY, 5'd0, 5'd0);
    send_request(OP_TOUCH, 5'd17, 5'd0);
    send_request(OP_TOUCH, 5'd31, 5'd31);
    send_request(OP_UNUSED, 5'd31, 5'd31);
    send_request(OP_RESIZE, 5'd0, 5'd16);
    // shrink clamps the remaining elements
    send_request(OP_RESIZE, 5'd0, 5'd5);
    send_request(OP_QUERY, 5'd5, 5'd0);
    send_request(OP_TOUCH, 5'd3, 5'd0);
    send_request(OP_QUERY, 5'd3, 5'd0);
    send_request(OP_RESIZE, 5'd0, 5'd1);
    send_request(OP_TOUCH, 5'd1, 5'd0);
    send_request(OP_QUERY, 5'd1, 5'd0);
    send_request(OP_RESIZE, 5'd0, 5'd0);
    send_request(OP_RESIZE, 5'd0, 5'd16);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i * 3) / RANDOM_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 82;
        default: idle_pct = 15;
      endcase
      send_random_request();
    end
    start <= 1'b0;

    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
